FILE: rtl/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants, beat types and tables for the cartesian to pt/eta/phi
// conversion pipeline.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int EFF_W         = (COORD_WIDTH < 24) ? COORD_WIDTH : 24;

  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = 6 + LOG_FRAC;
  localparam int NORM_STEPS = 6;
  localparam int LOG_LAT    = NORM_STEPS + LOG_FRAC;
  localparam int SQRT_CELLS = 32;

  localparam int XW = 43;   // CORDIC x/y datapath
  localparam int ZW = 24;   // CORDIC angle, Q.20

  localparam logic signed [ZW-1:0] PI_Q20  = 24'sd3294199;
  localparam logic signed [16:0]   PHI_LIM = 17'sd25736;
  localparam logic [31:0]          LN2_Q32 = 32'd2977044472;

  // pipeline stage numbers, input register is stage 1
  localparam int ST_IN   = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_SUM  = 3;
  localparam int ST_ROOT = ST_SUM + SQRT_CELLS;
  localparam int ST_PT   = ST_ROOT + 1;
  localparam int ST_LOG  = ST_PT + LOG_LAT;
  localparam int ST_D    = ST_LOG + 1;
  localparam int ST_PROD = ST_D + 1;
  localparam int LAST    = ST_PROD + 1;
  localparam int PHI_ST  = ST_SQ + CORDIC_STAGES + 1;

  typedef struct packed {
    logic signed [23:0] mom_x;
    logic signed [23:0] mom_y;
    logic signed [23:0] mom_z;
    logic signed [23:0] energy_in;
  } in_beat_t;

  typedef struct packed {
    logic [23:0]        trans_mom;
    logic signed [15:0] pseudorapidity;
    logic signed [15:0] azimuth;
    logic signed [23:0] energy_out;
    logic               eta_saturated;
  } out_beat_t;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] energy;
    logic               zneg;
    logic               stzero;
    logic [23:0]        az;
    logic [47:0]        st;
    logic [23:0]        pt;
    logic signed [15:0] phi;
    logic signed [15:0] eta;
    logic               flag;
  } meta_t;

  // round(atan(2^-i) * 2^20)
  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/crt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_in_if
// Input channel: one four-momentum per beat.
// ----------------------------------------------------------------------------
interface crt_in_if;
  import crt_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/crt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_out_if
// Output channel: pt, eta, phi, energy and saturation flag per beat.
// ----------------------------------------------------------------------------
interface crt_out_if;
  import crt_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/crt_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_sqrt_cell
// One restoring step of the integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
module crt_sqrt_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  input  logic [63:0] r_in,
  input  logic [63:0] b_in,
  output logic [63:0] n_out,
  output logic [63:0] r_out,
  output logic [63:0] b_out
);
  logic [64:0] trial;

  assign trial = {1'b0, r_in} + {1'b0, b_in};

  always_ff @(posedge clk) begin
    if (en) begin
      if ({1'b0, n_in} >= trial) begin
        n_out <= n_in - trial[63:0];
        r_out <= (r_in >> 1) + b_in;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
      b_out <= b_in >> 2;
    end
  end
endmodule

FILE: rtl/crt_log_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_log_cell
// One fraction bit of log2: square the Q1.31 mantissa, renormalise.
// ----------------------------------------------------------------------------
module crt_log_cell
  import crt_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         m_in,
  input  logic [LOG_W-1:0]    res_in,
  input  logic [LOG_FRAC-1:0] b_in,
  output logic [31:0]         m_out,
  output logic [LOG_W-1:0]    res_out,
  output logic [LOG_FRAC-1:0] b_out
);
  logic [63:0] sq;
  logic [32:0] m2;

  assign sq = 64'(m_in) * 64'(m_in);
  assign m2 = sq[63:31];

  always_ff @(posedge clk) begin
    if (en) begin
      if (m2[32]) begin
        m_out   <= m2[32:1];
        res_out <= res_in | {{(LOG_W-LOG_FRAC){1'b0}}, b_in};
      end else begin
        m_out   <= m2[31:0];
        res_out <= res_in;
      end
      b_out <= b_in >> 1;
    end
  end
endmodule

FILE: rtl/crt_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_log
// log2 in Q.24: staged leading-one normalisation then a row of squaring cells.
// ----------------------------------------------------------------------------
module crt_log
  import crt_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [63:0]      n_in,
  output logic [LOG_W-1:0] res_out
);
  logic [63:0]         nv [0:NORM_STEPS];
  logic [5:0]          lz [0:NORM_STEPS];
  logic [31:0]         cm   [0:LOG_FRAC];
  logic [LOG_W-1:0]    cres [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] cb   [0:LOG_FRAC];

  assign nv[0] = n_in;
  assign lz[0] = '0;

  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    always_ff @(posedge clk) begin
      if (en) begin
        if (nv[j][63 -: SH] == '0) begin
          nv[j+1] <= nv[j] << SH;
          lz[j+1] <= lz[j] + 6'(SH);
        end else begin
          nv[j+1] <= nv[j];
          lz[j+1] <= lz[j];
        end
      end
    end
  end

  // msb position becomes the integer part
  assign cm[0]   = nv[NORM_STEPS][63:32];
  assign cres[0] = {6'd63 - lz[NORM_STEPS], {LOG_FRAC{1'b0}}};
  assign cb[0]   = {1'b1, {(LOG_FRAC-1){1'b0}}};

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_cell
    crt_log_cell u_cell (
      .clk     (clk),
      .en      (en),
      .m_in    (cm[k]),
      .res_in  (cres[k]),
      .b_in    (cb[k]),
      .m_out   (cm[k+1]),
      .res_out (cres[k+1]),
      .b_out   (cb[k+1])
    );
  end

  assign res_out = cres[LOG_FRAC];
endmodule

FILE: rtl/crt_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_cordic_cell
// One vectoring micro-rotation; the stage index travels with the data.
// ----------------------------------------------------------------------------
module crt_cordic_cell
  import crt_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [4:0]           idx_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [4:0]           idx_out
);
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] ang;

  assign xs  = x_in >>> idx_in;
  assign ys  = y_in >>> idx_in;
  assign ang = atan_q20(idx_in);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ang;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ang;
      end
      idx_out <= idx_in + 5'd1;
    end
  end
endmodule

FILE: rtl/cartesian_to_pt_eta_phi.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_pt_eta_phi
// Converts (px, py, pz, E) into (pt, eta, phi, E) through a fixed pipeline.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  inp      in   mom_x, mom_y, mom_z, energy_in
//  res      out  trans_mom, pseudorapidity, azimuth, energy_out, eta_saturated
//
//  One beat per cycle sustained while the output queue has room. Stages in
//  order: input register, squares and sums, 32 square-root cells, pt and A,
//  the log2 unit, eta arithmetic, then the output queue.
//  A two-entry output queue decouples the sides; inp.ready drops only when it
//  is full, and then the whole pipeline holds.
//  rst is synchronous and clears the stage valid bits and the queue.
// ----------------------------------------------------------------------------
module cartesian_to_pt_eta_phi (
  input  logic      clk,
  input  logic      rst,
  crt_in_if.sink    inp,
  crt_out_if.source res
);
  import crt_pkg::*;

  function automatic logic signed [23:0] sext24(input logic [23:0] v);
    logic [23:0] r;
    for (int i = 0; i < 24; i++)
      r[i] = (i < EFF_W) ? v[i] : v[EFF_W-1];
    return $signed(r);
  endfunction

  logic en;
  meta_t side [1:LAST];
  meta_t side_next [1:LAST];

  logic signed [23:0] x1, y1;
  logic [23:0] ax1, ay1;
  logic [47:0] sqx, sqy, sqz;
  logic [63:0] s3;

  logic [63:0] an [0:SQRT_CELLS], ar [0:SQRT_CELLS], ab [0:SQRT_CELLS];
  logic [63:0] bn [0:SQRT_CELLS], br [0:SQRT_CELLS], bb [0:SQRT_CELLS];

  logic signed [XW-1:0] cx [0:CORDIC_STAGES], cy [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cz [0:CORDIC_STAGES];
  logic [4:0]           ci [0:CORDIC_STAGES];

  logic [32:0]       a_pt;
  logic [LOG_W-1:0]  la, ls;
  logic [LOG_W-1:0]  d67;
  logic [61:0]       prod68;

  logic signed [23:0]   xin, yin, zin;
  logic [23:0]          pt_c;
  logic signed [XW-1:0] x_ext, y_ext;
  logic signed [ZW-1:0] zr;
  logic signed [16:0]   phi_r;
  logic signed [15:0]   phi_c;
  logic signed [31:0]   diff;
  logic [61:0]          eta_sum;
  logic [16:0]          em, lim;
  logic [15:0]          eta_c;
  logic                 flag_c;

  // output queue
  out_beat_t obuf [0:1];
  logic      wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic push, pop;
  out_beat_t head_in;

  assign en        = (cnt != 2'd2);
  assign inp.ready = en;

  assign xin = sext24(inp.data.mom_x);
  assign yin = sext24(inp.data.mom_y);
  assign zin = sext24(inp.data.mom_z);

  // ---- squares and sums
  always_ff @(posedge clk) begin
    if (en) begin
      x1  <= xin;
      y1  <= yin;
      ax1 <= xin[23] ? 24'(-xin) : xin;
      ay1 <= yin[23] ? 24'(-yin) : yin;
      sqx <= 48'(ax1) * 48'(ax1);
      sqy <= 48'(ay1) * 48'(ay1);
      sqz <= 48'(side[ST_IN].az) * 48'(side[ST_IN].az);
      s3  <= {sqx + sqy + sqz, 16'b0};
    end
  end

  // ---- square roots: pt from st, R from s*2^16
  assign an[0] = {16'b0, side[ST_SUM].st};
  assign ar[0] = '0;
  assign ab[0] = 64'd1 << 62;
  assign bn[0] = s3;
  assign br[0] = '0;
  assign bb[0] = 64'd1 << 62;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    crt_sqrt_cell u_pt (
      .clk (clk), .en (en),
      .n_in (an[k]), .r_in (ar[k]), .b_in (ab[k]),
      .n_out (an[k+1]), .r_out (ar[k+1]), .b_out (ab[k+1])
    );
    crt_sqrt_cell u_r (
      .clk (clk), .en (en),
      .n_in (bn[k]), .r_in (br[k]), .b_in (bb[k]),
      .n_out (bn[k+1]), .r_out (br[k+1]), .b_out (bb[k+1])
    );
  end

  // round to nearest: remainder above root means the upper integer is closer
  assign pt_c = ar[SQRT_CELLS][23:0] + 24'(an[SQRT_CELLS] > ar[SQRT_CELLS]);

  always_ff @(posedge clk) begin
    if (en)
      a_pt <= {1'b0, side[ST_ROOT].az, 8'b0} + {1'b0, br[SQRT_CELLS][31:0]};
  end

  crt_log u_log_a (
    .clk (clk), .en (en), .n_in ({31'b0, a_pt}), .res_out (la)
  );
  crt_log u_log_s (
    .clk (clk), .en (en), .n_in ({16'b0, side[ST_PT].st}), .res_out (ls)
  );

  // ---- eta arithmetic
  assign diff = $signed(32'(la)) - $signed(32'(8 << LOG_FRAC))
              - $signed(32'(ls >> 1));

  always_ff @(posedge clk) begin
    if (en) begin
      d67    <= diff[31] ? '0 : diff[LOG_W-1:0];
      prod68 <= 62'(d67) * 62'(LN2_Q32);
    end
  end

  assign eta_sum = prod68 + (62'd1 << 44);
  assign lim     = side[ST_PROD].zneg ? 17'd32768 : 17'd32767;

  always_comb begin
    em     = eta_sum[61:45];
    flag_c = 1'b0;
    if (em > lim) begin
      em     = lim;
      flag_c = 1'b1;
    end
    eta_c = side[ST_PROD].zneg ? 16'(-em) : em[15:0];
    if (side[ST_PROD].stzero) begin
      eta_c  = side[ST_PROD].zneg ? 16'h8000 : 16'h7fff;
      flag_c = 1'b1;
    end
  end

  // ---- azimuth
  assign x_ext = XW'(x1) <<< 16;
  assign y_ext = XW'(y1) <<< 16;

  always_ff @(posedge clk) begin
    if (en) begin
      ci[0] <= '0;
      if (x1[23]) begin
        cx[0] <= -x_ext;
        cy[0] <= -y_ext;
        cz[0] <= y1[23] ? -PI_Q20 : PI_Q20;
      end else begin
        cx[0] <= x_ext;
        cy[0] <= y_ext;
        cz[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    crt_cordic_cell u_cell (
      .clk (clk), .en (en),
      .x_in (cx[k]), .y_in (cy[k]), .z_in (cz[k]), .idx_in (ci[k]),
      .x_out (cx[k+1]), .y_out (cy[k+1]), .z_out (cz[k+1]), .idx_out (ci[k+1])
    );
  end

  assign zr    = (cz[CORDIC_STAGES] + ZW'(64)) >>> 7;
  assign phi_r = zr[16:0];
  always_comb begin
    if (phi_r > PHI_LIM)
      phi_c = PHI_LIM[15:0];
    else if (phi_r < -PHI_LIM)
      phi_c = 16'(-PHI_LIM);
    else
      phi_c = phi_r[15:0];
  end

  // ---- sideband line
  always_comb begin
    side_next[ST_IN]        = side[ST_IN];
    side_next[ST_IN].valid  = inp.valid;
    side_next[ST_IN].energy = inp.data.energy_in;
    side_next[ST_IN].zneg   = zin[23];
    side_next[ST_IN].az     = zin[23] ? 24'(-zin) : zin;
    for (int k = ST_IN + 1; k <= LAST; k++)
      side_next[k] = side[k-1];
    side_next[ST_SUM].st     = sqx + sqy;
    side_next[ST_SUM].stzero = (sqx + sqy) == '0;
    side_next[ST_PT].pt      = pt_c;
    side_next[PHI_ST].phi    = phi_c;
    side_next[LAST].eta      = eta_c;
    side_next[LAST].flag     = flag_c;
    side_next[LAST].phi      = side[ST_PROD].stzero ? '0 : side[ST_PROD].phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = ST_IN; k <= LAST; k++)
        side[k].valid <= 1'b0;
    end else if (en) begin
      for (int k = ST_IN; k <= LAST; k++)
        side[k] <= side_next[k];
    end
  end

  // ---- output queue
  assign head_in.trans_mom      = side[LAST].pt;
  assign head_in.pseudorapidity = side[LAST].eta;
  assign head_in.azimuth        = side[LAST].phi;
  assign head_in.energy_out     = side[LAST].energy;
  assign head_in.eta_saturated  = side[LAST].flag;

  assign push = en && side[LAST].valid;
  assign pop  = res.valid && res.ready;

  assign res.valid = (cnt != 2'd0);
  assign res.data  = obuf[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      obuf[wr_ptr] <= head_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= ~wr_ptr;
      if (pop)
        rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
